// ----- hdl/fba_pkg.sv -----
`default_nettype none
package fba_pkg;

   // Number of blocks in the link memory and the widths that follow from it
   localparam int BLOCK_COUNT = 1024;
   localparam int IDX_W       = 10;
   localparam int EXT_W       = 11;
   localparam int STEP_W      = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [EXT_W-1:0] BLOCK_LIMIT = EXT_W'(BLOCK_COUNT);

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROW_STEP      = 2'd0,
      CSR_INITIAL_EXTENT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_GROW
   } state_type;

   // Link memory access: one write and one read address per cycle
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] granted_index;
      status_type       status;
   } result_type;

endpackage
`default_nettype wire

// ----- hdl/fba_ram.sv -----
`default_nettype none
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/fba_ctrl.sv -----
`default_nettype none
module fba_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire fba_pkg::op_type                 req_op,
   input  wire logic [fba_pkg::IDX_W-1:0]       req_block_index,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fba_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            out_free,
   output fba_pkg::mem_req_type                 mem_req,
   input  wire logic [fba_pkg::IDX_W-1:0]       mem_rd_data,
   output fba_pkg::result_type                  result
);

   fba_pkg::state_type state_ff, state_in;

   logic [fba_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [fba_pkg::EXT_W-1:0]  extent_ff, extent_in;
   logic [fba_pkg::STEP_W-1:0] grow_step_ff, grow_step_in;
   logic [fba_pkg::STEP_W-1:0] grow_count_ff, grow_count_in;
   logic [fba_pkg::IDX_W-1:0]  granted_ff, granted_in;

   logic                       req_accept;
   logic                       csr_accept;
   logic [fba_pkg::STEP_W-1:0] step;
   logic [fba_pkg::EXT_W:0]    grown_extent;
   logic                       can_grow;
   logic                       free_bad;
   logic                       grow_last;
   logic [fba_pkg::IDX_W-1:0]  grow_addr;
   logic [fba_pkg::EXT_W-1:0]  csr_extent;

   assign req_ready  = (state_ff == fba_pkg::S_IDLE) && out_free && !csr_valid;
   assign csr_ready  = (state_ff == fba_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_accept = csr_valid && csr_ready;

   // A zero grow step acts as one
   assign step         = (grow_step_ff == '0) ? fba_pkg::STEP_W'(1) : grow_step_ff;
   assign grown_extent = {1'b0, extent_ff} + (fba_pkg::EXT_W + 1)'(step);
   assign can_grow     = (extent_ff <= fba_pkg::BLOCK_LIMIT)
                      && (grown_extent <= {1'b0, fba_pkg::BLOCK_LIMIT});
   assign free_bad     = (req_block_index == '0)
                      || ({1'b0, req_block_index} >= extent_ff);
   assign grow_last    = ({1'b0, grow_count_ff} + 8'd1) == {1'b0, step};
   assign grow_addr    = extent_ff[fba_pkg::IDX_W-1:0]
                       + fba_pkg::IDX_W'(grow_count_ff);
   assign csr_extent   = (csr_wdata == '0) ? fba_pkg::EXT_W'(1) : csr_wdata;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fba_pkg::S_IDLE: begin
            if (req_accept && req_op == fba_pkg::OP_ALLOC) begin
               if (head_ff != '0) begin
                  state_in = fba_pkg::S_POP;
               end else if (can_grow) begin
                  state_in = fba_pkg::S_GROW;
               end
            end
         end
         fba_pkg::S_POP: begin
            state_in = fba_pkg::S_IDLE;
         end
         fba_pkg::S_GROW: begin
            if (grow_last) begin
               state_in = fba_pkg::S_IDLE;
            end
         end
         default: state_in = fba_pkg::S_IDLE;
      endcase
   end

   // Datapath, memory access and result
   always_comb begin
      head_in       = head_ff;
      extent_in     = extent_ff;
      grow_step_in  = grow_step_ff;
      grow_count_in = grow_count_ff;
      granted_in    = granted_ff;
      mem_req       = '0;
      result        = '0;
      result.status = fba_pkg::STATUS_OK;
      unique case (state_ff)
         fba_pkg::S_IDLE: begin
            if (csr_accept) begin
               unique case (csr_index)
                  fba_pkg::CSR_GROW_STEP: begin
                     grow_step_in = csr_wdata[fba_pkg::STEP_W-1:0];
                  end
                  fba_pkg::CSR_INITIAL_EXTENT: begin
                     extent_in = csr_extent;
                     head_in   = '0;
                  end
                  default: ;
               endcase
            end
            if (req_accept) begin
               if (req_op == fba_pkg::OP_FREE) begin
                  result.valid = 1'b1;
                  if (free_bad) begin
                     result.status = fba_pkg::STATUS_INVALID;
                  end else begin
                     // push onto the chain
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_block_index;
                     mem_req.wr_data = head_ff;
                     head_in         = req_block_index;
                  end
               end else if (head_ff != '0) begin
                  mem_req.rd_addr = head_ff;
                  granted_in      = head_ff;
               end else if (can_grow) begin
                  grow_count_in = '0;
               end else begin
                  result.valid  = 1'b1;
                  result.status = fba_pkg::STATUS_EXHAUSTED;
               end
            end
         end
         fba_pkg::S_POP: begin
            // pop: follow the link and clear it
            head_in         = mem_rd_data;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = granted_ff;
            mem_req.wr_data = '0;
            result.valid         = 1'b1;
            result.granted_index = granted_ff;
         end
         fba_pkg::S_GROW: begin
            // link new blocks in order; the first is handed out at once,
            // so its link is cleared, and the last ends the chain
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = grow_addr;
            mem_req.wr_data = (grow_count_ff == '0 || grow_last)
                            ? '0 : grow_addr + fba_pkg::IDX_W'(1);
            grow_count_in = grow_count_ff + fba_pkg::STEP_W'(1);
            if (grow_last) begin
               grow_count_in        = '0;
               extent_in            = grown_extent[fba_pkg::EXT_W-1:0];
               head_in              = (step == fba_pkg::STEP_W'(1)) ? '0
                                    : extent_ff[fba_pkg::IDX_W-1:0]
                                      + fba_pkg::IDX_W'(1);
               result.valid         = 1'b1;
               result.granted_index = extent_ff[fba_pkg::IDX_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fba_pkg::S_IDLE;
         head_ff       <= '0;
         extent_ff     <= fba_pkg::EXT_W'(1);
         grow_step_ff  <= fba_pkg::STEP_W'(10);
         grow_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         extent_ff     <= extent_in;
         grow_step_ff  <= grow_step_in;
         grow_count_ff <= grow_count_in;
      end
      granted_ff <= granted_in;
   end

endmodule
`default_nettype wire

// ----- hdl/free_list_block_allocator.sv -----
`default_nettype none
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: block_index; tuser: op
// rsp      out  rsp_tvalid/rsp_tready  tdata: granted_index, status
// csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// Free: one write of the link memory, none for an invalid index. Allocate from a
// non-empty chain: one read and one write of the link memory. Allocate from an empty
// chain: grow_step new blocks (a zero step acts as one), one link write per new block.
// Reset clears the chain head, sets the extent to 1 and grow_step to 10; the
// link memory is not cleared, every entry is written before it is read.
// A stalled result sits in the output register; the next request transfer shares its cycle.
module free_list_block_allocator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,  // [9:0] block_index
   input  wire logic                            req_tuser,  // [0] op
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [15:0]                          rsp_tdata,  // [9:0] granted_index,
                                                            // [11:10] status
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fba_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fba_pkg::mem_req_type       mem_req;
   fba_pkg::result_type        result;
   logic [fba_pkg::IDX_W-1:0]  mem_rd_data;
   logic                       out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // Output slot is free when empty or when its transfer completes now
   assign out_free = !rsp_valid_ff || rsp_tready;

   fba_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_op          (fba_pkg::op_type'(req_tuser)),
      .req_block_index (req_tdata[fba_pkg::IDX_W-1:0]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .out_free        (out_free),
      .mem_req         (mem_req),
      .mem_rd_data     (mem_rd_data),
      .result          (result)
   );

   // Next-link memory of the free chain
   fba_ram #(
      .WIDTH (fba_pkg::IDX_W),
      .DEPTH (fba_pkg::BLOCK_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   // Load a new result, else drop the slot once its transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, result.status, result.granted_index};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
